// File: rtl/bbbs_pkg.sv
// ----------------------------------------------------------------------------
// bbbs_pkg: shared types and constants of the ball-in-a-box stepper
// Sequencer states, operation codes, register indexes, control struct and
// the 32-bit saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package bbbs_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_APPLY,
      ST_DONE
   } state_type;

   // One pass of the shared multiplier per operation, in this order.
   typedef enum logic [2:0] {
      OP_GRAV,
      OP_POS_X,
      OP_POS_Y,
      OP_POS_Z,
      OP_REF_X,
      OP_REF_Y,
      OP_REF_Z
   } op_type;

   typedef enum logic [3:0] {
      CSR_GRAVITY,
      CSR_BOUNCE,
      CSR_X_LOW,
      CSR_X_HIGH,
      CSR_Y_LOW,
      CSR_Y_HIGH,
      CSR_Z_LOW,
      CSR_Z_HIGH
   } csr_index_type;

   localparam logic CMD_ADVANCE = 1'b0;
   localparam logic CMD_LOAD    = 1'b1;

   localparam int unsigned CSR_INDEX_W = 4;

   localparam logic signed [31:0] STICK_LIMIT = 32'sd655;
   localparam logic signed [31:0] STICK_PUSH  = 32'sd32768;

   localparam logic signed [35:0] S32_MAX_EXT = 36'sd2147483647;
   localparam logic signed [35:0] S32_MIN_EXT = -36'sd2147483648;

   typedef struct packed {
      logic   issue;
      logic   apply;
      logic   finish;
      op_type op;
   } ctl_type;

   function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
      logic signed [31:0] r;
      if (x > S32_MAX_EXT) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < S32_MIN_EXT) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/bbbs_mul.sv
// ----------------------------------------------------------------------------
// bbbs_mul: shared signed multiplier
// 33 x 17 signed product, registered; one product per cycle while enable is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bbbs_mul (
   input  wire logic               clock,
   input  wire logic               enable,
   input  wire logic signed [32:0] mul_a,
   input  wire logic signed [16:0] mul_b,
   output logic signed      [49:0] prod_ff
);

   logic signed [49:0] prod_in;

   assign prod_in = mul_a * mul_b;

   // hold the product until the next issue
   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/bbbs_ctrl.sv
// ----------------------------------------------------------------------------
// bbbs_ctrl: step sequencer
// Walks the operation list, with an issue state and then an apply state for each operation.
// ----------------------------------------------------------------------------
`default_nettype none

module bbbs_ctrl (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          command,
   input  wire logic          out_free,
   output logic               req_ready,
   output bbbs_pkg::ctl_type  ctl
);

   bbbs_pkg::state_type state_ff, state_in;
   bbbs_pkg::op_type    op_ff, op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bbbs_pkg::ST_IDLE;
         op_ff    <= bbbs_pkg::OP_GRAV;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      req_ready  = 1'b0;
      ctl.issue  = 1'b0;
      ctl.apply  = 1'b0;
      ctl.finish = 1'b0;
      ctl.op     = op_ff;
      unique case (state_ff)
         bbbs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (command == bbbs_pkg::CMD_LOAD) begin
                  state_in = bbbs_pkg::ST_DONE;
               end else begin
                  state_in = bbbs_pkg::ST_ISSUE;
                  op_in    = bbbs_pkg::OP_GRAV;
               end
            end
         end
         bbbs_pkg::ST_ISSUE: begin
            ctl.issue = 1'b1;
            state_in  = bbbs_pkg::ST_APPLY;
         end
         bbbs_pkg::ST_APPLY: begin
            ctl.apply = 1'b1;
            if (op_ff == bbbs_pkg::OP_REF_Z) begin
               state_in = bbbs_pkg::ST_DONE;
            end else begin
               op_in    = bbbs_pkg::op_type'(op_ff + 3'd1);
               state_in = bbbs_pkg::ST_ISSUE;
            end
         end
         bbbs_pkg::ST_DONE: begin
            // wait for the result register to drain
            if (out_free) begin
               ctl.finish = 1'b1;
               state_in   = bbbs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bbbs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/bouncing_ball_box_step_top.sv
// ----------------------------------------------------------------------------
// bouncing_ball_box_step_top: one ball stepped through a box in fixed point
// Advance: gravity on Y velocity, Euler position update, per-axis reflection
// off the box bounds with elasticity and floor anti-stick. Load: set state.
// ----------------------------------------------------------------------------
// Sequencing: an advance transfer makes 7 multiplier passes, each an issue
//   state and an apply state on the one shared 33x17 multiplier, then the
//   result handoff; a load transfer goes straight to the result handoff.
// Flow: a new transfer is taken only in the idle state, once the last one
//   is through its passes, as the shared multiplier serves one item at a time.
//   A finished result waits in the output register while the next transfer
//   is already accepted; a result still waiting at the end of the next item
//   holds the sequencer until it drains.
// Reset: synchronous, active high; ball state clears to zero, registers take
//   their defaults (gravity 1.0, elasticity ~0.7, box 0..10 on every axis).
`default_nettype none

module bouncing_ball_box_step_top (
   input  wire logic                clock,
   input  wire logic                reset,
   // input channel
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_command,
   input  wire logic        [15:0]  req_step_time,
   input  wire logic signed [31:0]  req_load_px,
   input  wire logic signed [31:0]  req_load_py,
   input  wire logic signed [31:0]  req_load_pz,
   input  wire logic signed [31:0]  req_load_vx,
   input  wire logic signed [31:0]  req_load_vy,
   input  wire logic signed [31:0]  req_load_vz,
   // result channel
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed      [31:0]  rsp_out_px,
   output logic signed      [31:0]  rsp_out_py,
   output logic signed      [31:0]  rsp_out_pz,
   output logic signed      [31:0]  rsp_out_vx,
   output logic signed      [31:0]  rsp_out_vy,
   output logic signed      [31:0]  rsp_out_vz,
   output logic             [2:0]   rsp_hit_mask,
   // configuration port
   input  wire logic                csr_we,
   input  wire logic [bbbs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic        [31:0]  csr_wdata
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic        [30:0] gravity_ff;
   logic        [15:0] bounce_ff;
   logic signed [31:0] low_ff  [0:2];
   logic signed [31:0] high_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff <= 31'd65536;
         bounce_ff  <= 16'd22938;
         for (int i = 0; i < 3; i++) begin
            low_ff[i]  <= 32'sd0;
            high_ff[i] <= 32'sd655360;
         end
      end else if (csr_we) begin
         // indexes past the list fall through and change nothing
         unique case (csr_index)
            bbbs_pkg::CSR_GRAVITY: gravity_ff <= csr_wdata[30:0];
            bbbs_pkg::CSR_BOUNCE:  bounce_ff  <= csr_wdata[15:0];
            bbbs_pkg::CSR_X_LOW:   low_ff[0]  <= csr_wdata;
            bbbs_pkg::CSR_X_HIGH:  high_ff[0] <= csr_wdata;
            bbbs_pkg::CSR_Y_LOW:   low_ff[1]  <= csr_wdata;
            bbbs_pkg::CSR_Y_HIGH:  high_ff[1] <= csr_wdata;
            bbbs_pkg::CSR_Z_LOW:   low_ff[2]  <= csr_wdata;
            bbbs_pkg::CSR_Z_HIGH:  high_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   bbbs_pkg::ctl_type ctl;
   logic              rsp_valid_ff;
   logic              out_free;
   logic              req_fire;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_fire = req_valid && req_ready;

   bbbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .command   (req_command),
      .out_free  (out_free),
      .req_ready (req_ready),
      .ctl       (ctl)
   );

   // ------------------------------------------------------------------
   // Ball state and per-step scratch
   // ------------------------------------------------------------------
   logic signed [31:0] pos_ff [0:2];
   logic signed [31:0] pos_in [0:2];
   logic signed [31:0] vel_ff [0:2];
   logic signed [31:0] vel_in [0:2];
   logic        [15:0] dt_ff;
   logic        [2:0]  hits_ff, hits_in;
   logic               hit_lo_ff, hit_lo_in;
   logic               hit_hi_ff, hit_hi_in;

   // Axis that the current operation works on; gravity acts on Y.
   logic [1:0] axis;

   always_comb begin
      unique case (ctl.op) inside
         bbbs_pkg::OP_POS_X, bbbs_pkg::OP_REF_X: axis = 2'd0;
         bbbs_pkg::OP_POS_Z, bbbs_pkg::OP_REF_Z: axis = 2'd2;
         default:                                axis = 2'd1;
      endcase
   end

   logic signed [31:0] sel_pos;
   logic signed [31:0] sel_vel;
   logic signed [31:0] sel_low;
   logic signed [31:0] sel_high;
   logic               is_reflect;

   assign sel_pos    = pos_ff[axis];
   assign sel_vel    = vel_ff[axis];
   assign sel_low    = low_ff[axis];
   assign sel_high   = high_ff[axis];
   assign is_reflect = (ctl.op == bbbs_pkg::OP_REF_X) || (ctl.op == bbbs_pkg::OP_REF_Y)
                    || (ctl.op == bbbs_pkg::OP_REF_Z);

   // ------------------------------------------------------------------
   // Shared multiplier: operand select in the issue cycle
   // ------------------------------------------------------------------
   logic signed [32:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [49:0] prod_ff;

   always_comb begin
      if (ctl.op == bbbs_pkg::OP_GRAV) begin
         mul_a = $signed({2'b00, gravity_ff});
         mul_b = $signed({1'b0, dt_ff});
      end else if (is_reflect) begin
         // negate first so the floor applies to the reflected velocity
         mul_a = -$signed({sel_vel[31], sel_vel});
         mul_b = $signed({1'b0, bounce_ff});
      end else begin
         mul_a = $signed({sel_vel[31], sel_vel});
         mul_b = $signed({1'b0, dt_ff});
      end
   end

   bbbs_mul u_mul (
      .clock   (clock),
      .enable  (ctl.issue),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   // ------------------------------------------------------------------
   // Apply cycle: shift, accumulate, saturate, clamp
   // ------------------------------------------------------------------
   logic signed [33:0] prod_s16;
   logic signed [34:0] prod_s15;
   logic signed [35:0] acc_sum;
   logic signed [31:0] acc_sat;
   logic signed [31:0] refl_sat;

   assign prod_s16 = $signed(prod_ff[49:16]);
   assign prod_s15 = $signed(prod_ff[49:15]);
   assign refl_sat = bbbs_pkg::sat32({prod_s15[34], prod_s15});

   always_comb begin
      if (ctl.op == bbbs_pkg::OP_GRAV) begin
         acc_sum = $signed({{4{sel_vel[31]}}, sel_vel})
                 - $signed({{2{prod_s16[33]}}, prod_s16});
      end else begin
         acc_sum = $signed({{4{sel_pos[31]}}, sel_pos})
                 + $signed({{2{prod_s16[33]}}, prod_s16});
      end
   end

   assign acc_sat = bbbs_pkg::sat32(acc_sum);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pos_in[i] = pos_ff[i];
         vel_in[i] = vel_ff[i];
      end
      hits_in   = hits_ff;
      hit_lo_in = hit_lo_ff;
      hit_hi_in = hit_hi_ff;

      if (req_fire) begin
         hits_in = 3'b000;
         if (req_command == bbbs_pkg::CMD_LOAD) begin
            pos_in[0] = req_load_px;
            pos_in[1] = req_load_py;
            pos_in[2] = req_load_pz;
            vel_in[0] = req_load_vx;
            vel_in[1] = req_load_vy;
            vel_in[2] = req_load_vz;
         end
      end

      // latch bound contact while the reflection product is formed
      if (ctl.issue && is_reflect) begin
         hit_lo_in = (sel_pos <= sel_low);
         hit_hi_in = (sel_pos >= sel_high);
      end

      if (ctl.apply) begin
         if (ctl.op == bbbs_pkg::OP_GRAV) begin
            vel_in[axis] = acc_sat;
         end else if (!is_reflect) begin
            pos_in[axis] = acc_sat;
         end else if (hit_lo_ff || hit_hi_ff) begin
            // low bound wins when both match
            pos_in[axis]  = hit_lo_ff ? sel_low : sel_high;
            vel_in[axis]  = refl_sat;
            hits_in[axis] = 1'b1;
            // floor anti-stick: kick a nearly dead ball back up
            if (ctl.op == bbbs_pkg::OP_REF_Y && hit_lo_ff
                && refl_sat > -bbbs_pkg::STICK_LIMIT
                && refl_sat < bbbs_pkg::STICK_LIMIT) begin
               vel_in[axis] = bbbs_pkg::STICK_PUSH;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= 32'sd0;
            vel_ff[i] <= 32'sd0;
         end
         hits_ff <= 3'b000;
      end else begin
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= pos_in[i];
            vel_ff[i] <= vel_in[i];
         end
         hits_ff <= hits_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         dt_ff <= req_step_time;
      end
      hit_lo_ff <= hit_lo_in;
      hit_hi_ff <= hit_hi_in;
   end

   // ------------------------------------------------------------------
   // Result register: snapshot of the state, held until transfer
   // ------------------------------------------------------------------
   logic signed [31:0] rsp_px_ff, rsp_py_ff, rsp_pz_ff;
   logic signed [31:0] rsp_vx_ff, rsp_vy_ff, rsp_vz_ff;
   logic        [2:0]  rsp_hits_ff;
   logic               rsp_valid_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         rsp_px_ff   <= pos_ff[0];
         rsp_py_ff   <= pos_ff[1];
         rsp_pz_ff   <= pos_ff[2];
         rsp_vx_ff   <= vel_ff[0];
         rsp_vy_ff   <= vel_ff[1];
         rsp_vz_ff   <= vel_ff[2];
         rsp_hits_ff <= hits_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_px   = rsp_px_ff;
   assign rsp_out_py   = rsp_py_ff;
   assign rsp_out_pz   = rsp_pz_ff;
   assign rsp_out_vx   = rsp_vx_ff;
   assign rsp_out_vy   = rsp_vy_ff;
   assign rsp_out_vz   = rsp_vz_ff;
   assign rsp_hit_mask = rsp_hits_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // a pending result is never overwritten before its transfer
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before transfer");

   // every multiplier issue is followed by its apply cycle
   a_issue_apply: assert property (@(posedge clock) disable iff (reset)
      ctl.issue |=> ctl.apply)
      else $error("multiplier product not applied");

   // the block is busy right after it takes an item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("second item accepted while busy");

   // a load result carries no wall contact
   a_load_no_hits: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_command == bbbs_pkg::CMD_LOAD) |=> (hits_ff == 3'b000))
      else $error("load result reports wall contact");

endmodule

`default_nettype wire
